### sv/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// Holds port field widths, register map codes and the stage flag struct.
// No dependencies; used by every module of the block.
`default_nettype none

package blr_pkg;

   // Port field widths
   localparam int COORD_W    = 16;
   localparam int COLOR_W    = 24;
   localparam int ADDR_W     = 20;
   localparam int CFG_W      = 11;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   // Request kinds
   typedef enum logic [0:0] {
      MODE_START = 1'b0,
      MODE_STEP  = 1'b1
   } mode_type;

   // Per-pixel flags handed from the step stage to the clip stage
   typedef struct packed {
      logic idle;
      logic last;
   } pixel_flags_type;

endpackage

`default_nettype wire

### sv/bresenham_line_raster.sv
// Bresenham line rasterizer for all octants, one pixel per request.
// Usage:
//   req channel: tuser is the mode (0 starts a line from tdata's endpoints and
//   color, 1 advances one pixel). Every request yields exactly one response.
//   rsp channel: tdata carries pixel coordinates, frame-buffer address and color;
//   tuser carries visible and idle; tlast marks the line's end point. A step
//   with no active line answers with idle set and all other fields zero.
//   csr port: frame width at byte 0, frame height at byte 4 (11 bits each,
//   reset 1024); write them only while no request is in flight.
// Pipeline: the step stage updates the line state and registers the pixel, then
//   the clip stage runs the bounds test and the row-times-width multiply into the
//   result register. One request per cycle is taken sustained while rsp_tready
//   stays high.
// Reset clears both stage valids and drops any active line; the screen size
//   returns to 1024 by 1024.
// When rsp_tready is low the result register holds; the step stage still takes
//   one more request, and req_tready falls only once both stages are full.
// Depends on blr_pkg, blr_step and blr_clip.
`default_nettype none

module bresenham_line_raster #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Request: x_start, y_start, x_end, y_end, line_color
   input  wire  [blr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Request: mode
   input  wire                                 req_tuser,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // Response: pixel_x, pixel_y, pixel_address, pixel_color, zero pad
   output logic [blr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Response: visible, idle
   output logic [blr_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [blr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [blr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [blr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = blr_pkg::COORD_W;

   logic [blr_pkg::CFG_W-1:0]      width_ff, height_ff;
   blr_pkg::csr_reg_type           csr_reg;
   logic                           csr_write;

   logic                           s1_valid, s1_ready;
   logic signed [COORD_BITS-1:0]   s1_x, s1_y;
   logic [blr_pkg::COLOR_W-1:0]    s1_color;
   blr_pkg::pixel_flags_type       s1_flags;

   logic [CW-1:0]                  pix_x, pix_y;
   logic [blr_pkg::ADDR_W-1:0]     pix_addr;
   logic [blr_pkg::COLOR_W-1:0]    pix_color;
   logic                           pix_vis, pix_last, pix_idle;

   // Register file
   assign csr_reg    = blr_pkg::csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blr_pkg::FRAME_WIDTH_RESET;
         height_ff <= blr_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_reg)
            blr_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[blr_pkg::CFG_W-1:0];
            blr_pkg::REG_FRAME_HEIGHT: height_ff <= csr_pwdata[blr_pkg::CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         blr_pkg::REG_FRAME_WIDTH:  csr_prdata = blr_pkg::CSR_DATA_W'(width_ff);
         blr_pkg::REG_FRAME_HEIGHT: csr_prdata = blr_pkg::CSR_DATA_W'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Line stepping
   blr_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_mode    (blr_pkg::mode_type'(req_tuser)),
      .in_x_start (req_tdata[CW-1:0]),
      .in_y_start (req_tdata[2*CW-1:CW]),
      .in_x_end   (req_tdata[3*CW-1:2*CW]),
      .in_y_end   (req_tdata[4*CW-1:3*CW]),
      .in_color   (req_tdata[4*CW+blr_pkg::COLOR_W-1:4*CW]),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_x      (s1_x),
      .out_y      (s1_y),
      .out_color  (s1_color),
      .out_flags  (s1_flags)
   );

   // Clipping and addressing
   blr_clip #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COORD_BITS (COORD_BITS)
   ) u_clip (
      .clock         (clock),
      .reset         (reset),
      .frame_width   (width_ff),
      .frame_height  (height_ff),
      .in_valid      (s1_valid),
      .in_ready      (s1_ready),
      .in_x          (s1_x),
      .in_y          (s1_y),
      .in_color      (s1_color),
      .in_flags      (s1_flags),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_x         (pix_x),
      .out_y         (pix_y),
      .out_address   (pix_addr),
      .out_color     (pix_color),
      .out_visible   (pix_vis),
      .out_last      (pix_last),
      .out_idle      (pix_idle)
   );

   // Pack the response
   assign rsp_tdata = blr_pkg::RSP_DATA_W'({pix_color, pix_addr, pix_y, pix_x});
   assign rsp_tuser = {pix_idle, pix_vis};
   assign rsp_tlast = pix_last;

endmodule

`default_nettype wire

### sv/blr_step.sv
// Bresenham step stage: line state registers and one stage register of pixel data.
// A start request loads the line, a step request advances one pixel.
// Depends on blr_pkg.
`default_nettype none

module blr_step #(
   parameter int COORD_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire  blr_pkg::mode_type             in_mode,
   input  wire  [blr_pkg::COORD_W-1:0]         in_x_start,
   input  wire  [blr_pkg::COORD_W-1:0]         in_y_start,
   input  wire  [blr_pkg::COORD_W-1:0]         in_x_end,
   input  wire  [blr_pkg::COORD_W-1:0]         in_y_end,
   input  wire  [blr_pkg::COLOR_W-1:0]         in_color,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic signed [COORD_BITS-1:0]        out_x,
   output logic signed [COORD_BITS-1:0]        out_y,
   output logic [blr_pkg::COLOR_W-1:0]         out_color,
   output blr_pkg::pixel_flags_type            out_flags
);

   localparam int CB    = COORD_BITS;
   localparam int EXT_W = (CB > blr_pkg::COORD_W) ? CB : blr_pkg::COORD_W;
   localparam int ERR_W = CB + 3;

   // Line state
   logic signed [CB-1:0]           cur_x_ff, cur_x_in;
   logic signed [CB-1:0]           cur_y_ff, cur_y_in;
   logic signed [CB-1:0]           tgt_x_ff, tgt_x_in;
   logic signed [CB-1:0]           tgt_y_ff, tgt_y_in;
   logic [CB:0]                    dx_ff, dx_in;
   logic [CB:0]                    dy_ff, dy_in;
   logic                           left_ff, left_in;
   logic                           up_ff, up_in;
   logic signed [ERR_W-1:0]        err_ff, err_in;
   logic [blr_pkg::COLOR_W-1:0]    color_ff, color_in;
   logic                           active_ff, active_in;

   // Stage register
   logic                           valid_ff, valid_in;
   logic signed [CB-1:0]           px_ff, px_in;
   logic signed [CB-1:0]           py_ff, py_in;
   logic [blr_pkg::COLOR_W-1:0]    pcolor_ff, pcolor_in;
   blr_pkg::pixel_flags_type       pflags_ff, pflags_in;

   logic [EXT_W-1:0]               xs_ext, ys_ext, xe_ext, ye_ext;
   logic signed [CB-1:0]           x0, y0, x1, y1;
   logic signed [CB:0]             diff_x, diff_y;
   logic [CB:0]                    start_dx, start_dy;
   logic signed [ERR_W-1:0]        dx_s, dy_s, e2;
   logic                           move_x, move_y;
   logic                           accept, is_last;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Read endpoints as COORD_BITS-wide two's complement
   assign xs_ext = EXT_W'(in_x_start);
   assign ys_ext = EXT_W'(in_y_start);
   assign xe_ext = EXT_W'(in_x_end);
   assign ye_ext = EXT_W'(in_y_end);
   assign x0 = $signed(xs_ext[CB-1:0]);
   assign y0 = $signed(ys_ext[CB-1:0]);
   assign x1 = $signed(xe_ext[CB-1:0]);
   assign y1 = $signed(ye_ext[CB-1:0]);

   // Absolute deltas for a new line
   assign diff_x   = (CB+1)'(x1) - (CB+1)'(x0);
   assign diff_y   = (CB+1)'(y1) - (CB+1)'(y0);
   assign start_dx = diff_x[CB] ? $unsigned(-diff_x) : $unsigned(diff_x);
   assign start_dy = diff_y[CB] ? $unsigned(-diff_y) : $unsigned(diff_y);

   // Error decisions for one step
   assign dx_s   = $signed({2'b00, dx_ff});
   assign dy_s   = $signed({2'b00, dy_ff});
   assign e2     = err_ff <<< 1;
   assign move_x = e2 > -dy_s;
   assign move_y = e2 < dx_s;

   // Next line state and pixel
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      left_in   = left_ff;
      up_in     = up_ff;
      err_in    = err_ff;
      color_in  = color_ff;
      active_in = active_ff;

      unique case (in_mode)
         blr_pkg::MODE_START: begin
            cur_x_in = x0;
            cur_y_in = y0;
            tgt_x_in = x1;
            tgt_y_in = y1;
            dx_in    = start_dx;
            dy_in    = start_dy;
            left_in  = !(x0 < x1);
            up_in    = !(y0 < y1);
            err_in   = $signed({2'b00, start_dx}) - $signed({2'b00, start_dy});
            color_in = in_color;
         end
         blr_pkg::MODE_STEP: begin
            if (active_ff) begin
               err_in = err_ff - (move_x ? dy_s : ERR_W'(0)) + (move_y ? dx_s : ERR_W'(0));
               if (move_x) begin
                  cur_x_in = left_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
               end
               if (move_y) begin
                  cur_y_in = up_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
               end
            end
         end
         default: begin
         end
      endcase

      is_last = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      pflags_in.idle = (in_mode == blr_pkg::MODE_STEP) && !active_ff;
      pflags_in.last = is_last && !pflags_in.idle;
      if (!pflags_in.idle) begin
         active_in = !is_last;
      end
      px_in     = pflags_in.idle ? '0 : cur_x_in;
      py_in     = pflags_in.idle ? '0 : cur_y_in;
      pcolor_in = pflags_in.idle ? '0 : color_in;
   end

   // Stage valid: fill on accept, drain when taken
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         left_ff   <= 1'b0;
         up_ff     <= 1'b0;
         err_ff    <= '0;
         color_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            active_ff <= active_in;
            cur_x_ff  <= cur_x_in;
            cur_y_ff  <= cur_y_in;
            tgt_x_ff  <= tgt_x_in;
            tgt_y_ff  <= tgt_y_in;
            dx_ff     <= dx_in;
            dy_ff     <= dy_in;
            left_ff   <= left_in;
            up_ff     <= up_in;
            err_ff    <= err_in;
            color_ff  <= color_in;
         end
      end
   end

   // Pixel payload
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         pcolor_ff <= pcolor_in;
         pflags_ff <= pflags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = px_ff;
   assign out_y     = py_ff;
   assign out_color = pcolor_ff;
   assign out_flags = pflags_ff;

endmodule

`default_nettype wire

### sv/blr_clip.sv
// Clip and address stage: screen bounds test and frame-buffer address multiply.
// Registers the final pixel result for the output channel.
// Depends on blr_pkg.
`default_nettype none

module blr_clip #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [blr_pkg::CFG_W-1:0]           frame_width,
   input  wire  [blr_pkg::CFG_W-1:0]           frame_height,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire  signed [COORD_BITS-1:0]        in_x,
   input  wire  signed [COORD_BITS-1:0]        in_y,
   input  wire  [blr_pkg::COLOR_W-1:0]         in_color,
   input  wire  blr_pkg::pixel_flags_type      in_flags,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic [blr_pkg::COORD_W-1:0]         out_x,
   output logic [blr_pkg::COORD_W-1:0]         out_y,
   output logic [blr_pkg::ADDR_W-1:0]          out_address,
   output logic [blr_pkg::COLOR_W-1:0]         out_color,
   output logic                                out_visible,
   output logic                                out_last,
   output logic                                out_idle
);

   localparam int CB    = COORD_BITS;
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int HB2   = $clog2(MAX_HEIGHT + 1);
   localparam int LW0   = (WB > blr_pkg::CFG_W) ? WB : blr_pkg::CFG_W;
   localparam int LW    = (HB2 > LW0) ? HB2 : LW0;
   localparam int CMPW  = ((CB > LW) ? CB : LW) + 1;
   localparam int XB    = $clog2(MAX_WIDTH);
   localparam int HB    = $clog2(MAX_HEIGHT);
   localparam int PW    = HB + LW + 1;
   localparam int SUMW  = (PW > blr_pkg::ADDR_W) ? PW : blr_pkg::ADDR_W;
   localparam logic [LW-1:0] W_MAX = LW'(MAX_WIDTH);
   localparam logic [LW-1:0] H_MAX = LW'(MAX_HEIGHT);

   logic                           valid_ff, valid_in;
   logic [blr_pkg::COORD_W-1:0]    x_ff, y_ff;
   logic [blr_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [blr_pkg::COLOR_W-1:0]    color_ff;
   logic                           vis_ff, vis_in;
   logic                           last_ff, idle_ff;

   logic [LW-1:0]                  w_cfg, h_cfg, w_lim, h_lim;
   logic signed [CMPW-1:0]         x_c, y_c, w_c, h_c;
   logic [SUMW-1:0]                addr_sum;
   logic                           accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Limit the screen size to the largest supported frame
   assign w_cfg = LW'(frame_width);
   assign h_cfg = LW'(frame_height);
   assign w_lim = (w_cfg < W_MAX) ? w_cfg : W_MAX;
   assign h_lim = (h_cfg < H_MAX) ? h_cfg : H_MAX;

   // Bounds test
   assign x_c = CMPW'(in_x);
   assign y_c = CMPW'(in_y);
   assign w_c = $signed(CMPW'(w_lim));
   assign h_c = $signed(CMPW'(h_lim));
   assign vis_in = !in_flags.idle && !in_x[CB-1] && !in_y[CB-1] && (x_c < w_c) && (y_c < h_c);

   // Row-major address, kept to the address width
   assign addr_sum = SUMW'(in_y[HB-1:0]) * SUMW'(w_lim) + SUMW'(in_x[XB-1:0]);
   assign addr_in  = vis_in ? addr_sum[blr_pkg::ADDR_W-1:0] : '0;

   // Result valid: fill on accept, drain when taken
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= blr_pkg::COORD_W'(in_x);
         y_ff     <= blr_pkg::COORD_W'(in_y);
         addr_ff  <= addr_in;
         color_ff <= in_color;
         vis_ff   <= vis_in;
         last_ff  <= in_flags.last;
         idle_ff  <= in_flags.idle;
      end
   end

   assign out_valid   = valid_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_address = addr_ff;
   assign out_color   = color_ff;
   assign out_visible = vis_ff;
   assign out_last    = last_ff;
   assign out_idle    = idle_ff;

endmodule

`default_nettype wire
